/* hdl/pft_pkg.sv */
// Shared types and constants for the page frame table unit.
`default_nettype none

package pft_pkg;

  // Field widths fixed by the stream payload layout
  localparam int REQ_W       = 2;
  localparam int PAGE_W      = 32;
  localparam int STATUS_W    = 2;
  localparam int SLOT_IDX_W  = 4;
  localparam int IN_TDATA_W  = 32;
  localparam int OUT_TDATA_W = 40;

  // Request kinds
  localparam logic [REQ_W-1:0] REQ_NEW   = 2'd0;
  localparam logic [REQ_W-1:0] REQ_GET   = 2'd1;
  localparam logic [REQ_W-1:0] REQ_EVICT = 2'd2;
  localparam logic [REQ_W-1:0] REQ_POP   = 2'd3;

  // Result status codes
  localparam logic [STATUS_W-1:0] ST_OK     = 2'd0;
  localparam logic [STATUS_W-1:0] ST_MISS   = 2'd1;
  localparam logic [STATUS_W-1:0] ST_ABSENT = 2'd2;

  typedef enum logic [1:0] {
    PFT_IDLE,
    PFT_SEARCH,
    PFT_RESOLVE
  } pft_state_t;

  // Controller to datapath commands
  typedef struct packed {
    logic load;    // capture the incoming request
    logic search;  // register compare and candidate vectors
    logic commit;  // update table, load result register
  } pft_cmd_t;

endpackage

`default_nettype wire

/* hdl/pft_ctrl.sv */
// Request sequencing state machine and result valid flag.
`default_nettype none

module pft_ctrl (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_tvalid,
  output logic                in_tready,
  output logic                out_tvalid,
  input  wire logic           out_tready,
  output pft_pkg::pft_cmd_t   cmd
);
  import pft_pkg::*;

  pft_state_t state_r, state_nxt;
  logic       out_valid_r, out_valid_nxt;
  logic       out_free;

  // result register can take a new value this cycle
  assign out_free = !out_valid_r || out_tready;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      PFT_IDLE:    if (in_tvalid) state_nxt = PFT_SEARCH;
      PFT_SEARCH:  state_nxt = PFT_RESOLVE;
      PFT_RESOLVE: if (out_free) state_nxt = PFT_IDLE;
      default:     state_nxt = PFT_IDLE;
    endcase
  end

  always_comb begin
    in_tready  = 1'b0;
    cmd        = '0;
    case (state_r)
      PFT_IDLE: begin
        in_tready = 1'b1;
        cmd.load  = in_tvalid;
      end
      PFT_SEARCH:  cmd.search = 1'b1;
      PFT_RESOLVE: cmd.commit = out_free;
      default: ;
    endcase
  end

  always_comb begin
    if (cmd.commit) begin
      out_valid_nxt = 1'b1;
    end else if (out_tready) begin
      out_valid_nxt = 1'b0;
    end else begin
      out_valid_nxt = out_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= PFT_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_tvalid = out_valid_r;

endmodule

`default_nettype wire

/* hdl/pft_dp.sv */
// Frame table storage, page compare, rotating slot pick and result register.
`default_nettype none

module pft_dp #(
  parameter int SLOTS     = 16,
  parameter int PAGE_BITS = 32
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire pft_pkg::pft_cmd_t                 cmd,
  input  wire logic [pft_pkg::REQ_W-1:0]         in_req,
  input  wire logic [pft_pkg::IN_TDATA_W-1:0]    in_page,
  output logic      [pft_pkg::OUT_TDATA_W-1:0]   out_tdata,
  output logic                                   out_tuser
);
  import pft_pkg::*;

  localparam int HW = $clog2(SLOTS);
  localparam int CW = (PAGE_BITS < PAGE_W) ? PAGE_BITS : PAGE_W;
  localparam int SW = (HW < SLOT_IDX_W) ? HW : SLOT_IDX_W;

  logic [PAGE_BITS-1:0] page_mem_r [SLOTS];
  logic [SLOTS-1:0]     present_r, present_nxt;
  logic [HW-1:0]        hand_r, hand_nxt;

  logic [REQ_W-1:0]     req_r;
  logic [PAGE_BITS-1:0] pg_r, pg_in;

  logic [SLOTS-1:0]     vec_r, hi_r, vec_nxt, hi_nxt, match;
  logic                 full_r;
  logic [PAGE_BITS-1:0] cand_pg_r;

  logic [SLOTS-1:0]     pick, onehot;
  logic                 any;
  logic [HW-1:0]        sel_idx;
  logic [PAGE_BITS-1:0] sel_page;

  logic [STATUS_W-1:0]   res_status;
  logic [SLOT_IDX_W-1:0] res_slot;
  logic [PAGE_W-1:0]     res_page;
  logic                  res_cand;
  logic [PAGE_BITS-1:0]  res_page_wide;

  logic [STATUS_W-1:0]   out_status_r;
  logic [SLOT_IDX_W-1:0] out_slot_r;
  logic [PAGE_W-1:0]     out_page_r;
  logic                  out_cand_r;

  logic                  wr_en;

  always_comb begin
    pg_in         = '0;
    pg_in[CW-1:0] = in_page[CW-1:0];
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      req_r <= in_req;
      pg_r  <= pg_in;
    end
  end

  // search: per-slot compare, select vector, mask from the hand upward
  always_comb begin
    for (int i = 0; i < SLOTS; i++) begin
      match[i] = present_r[i] && (page_mem_r[i] == pg_r);
    end
    case (req_r)
      REQ_NEW:   vec_nxt = ~present_r;
      REQ_GET,
      REQ_EVICT: vec_nxt = match;
      REQ_POP:   vec_nxt = present_r;
      default:   vec_nxt = present_r;
    endcase
    for (int i = 0; i < SLOTS; i++) begin
      hi_nxt[i] = vec_nxt[i] && (HW'(i) >= hand_r);
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.search) begin
      vec_r     <= vec_nxt;
      hi_r      <= hi_nxt;
      full_r    <= &present_r;
      cand_pg_r <= page_mem_r[hand_r];
    end
  end

  // resolve: first set bit from the hand on, wrapping
  always_comb begin
    any      = |vec_r;
    pick     = (|hi_r) ? hi_r : vec_r;
    onehot   = pick & (~pick + SLOTS'(1));
    sel_idx  = '0;
    sel_page = '0;
    for (int i = 0; i < SLOTS; i++) begin
      if (onehot[i]) begin
        sel_idx  = sel_idx | HW'(i);
        sel_page = sel_page | page_mem_r[i];
      end
    end
  end

  always_comb begin
    res_status    = ST_MISS;
    res_cand      = 1'b0;
    res_page_wide = '0;
    res_slot      = '0;
    present_nxt   = present_r;
    hand_nxt      = hand_r;
    wr_en         = 1'b0;
    case (req_r)
      REQ_NEW: begin
        if (any) begin
          res_status           = ST_OK;
          present_nxt[sel_idx] = 1'b1;
          wr_en                = 1'b1;
          hand_nxt = (sel_idx == HW'(SLOTS - 1)) ? '0 : HW'(sel_idx + 1'b1);
        end else begin
          res_cand      = 1'b1;
          res_page_wide = cand_pg_r;
        end
      end
      REQ_GET: begin
        if (any) begin
          res_status = ST_OK;
        end else if (full_r) begin
          res_cand      = 1'b1;
          res_page_wide = cand_pg_r;
        end
      end
      REQ_EVICT: begin
        if (any) begin
          res_status           = ST_OK;
          present_nxt[sel_idx] = 1'b0;
          hand_nxt             = sel_idx;
        end else begin
          res_status = ST_ABSENT;
        end
      end
      REQ_POP: begin
        if (any) begin
          res_status           = ST_OK;
          present_nxt[sel_idx] = 1'b0;
          res_page_wide        = sel_page;
        end
      end
      default: ;
    endcase
    if (res_status == ST_OK) begin
      res_slot[SW-1:0] = sel_idx[SW-1:0];
    end
    res_page         = '0;
    res_page[CW-1:0] = res_page_wide[CW-1:0];
  end

  always_ff @(posedge clk) begin
    if (cmd.commit && wr_en) begin
      page_mem_r[sel_idx] <= pg_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      present_r <= '0;
      hand_r    <= '0;
    end else if (cmd.commit) begin
      present_r <= present_nxt;
      hand_r    <= hand_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_status_r <= res_status;
      out_slot_r   <= res_slot;
      out_page_r   <= res_page;
      out_cand_r   <= res_cand;
    end
  end

  assign out_tdata = {2'b00, out_page_r, out_slot_r, out_status_r};
  assign out_tuser = out_cand_r;

endmodule

`default_nettype wire

/* hdl/page_frame_table_unit.sv */
// Top level of the round-robin page frame table unit.
`default_nettype none

// Channel   Dir  tdata (low bit up)                        tuser
// in_       in   page_number[31:0]                         req_type[1:0]
// out_      out  status[1:0] slot_index[5:2]               candidate_valid
//                result_page[37:6], zero pad [39:38]
//
// A request is taken in the idle state, its slots are compared in parallel
// in the search state, and the rotating pick and table update land in the
// resolve state; no new request is taken until the current one has resolved.
// The input is ready again while a result still waits in the output register;
// the resolve step holds until that register is free.
// Reset clears the present flags, the hand and the controller; page storage
// is left as is and only the pages of present slots reach a result.

module page_frame_table_unit #(
  parameter int SLOTS     = 16,
  parameter int PAGE_BITS = 32
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire logic                              in_tvalid,
  output logic                                   in_tready,
  input  wire logic [pft_pkg::IN_TDATA_W-1:0]    in_tdata,  // page_number
  input  wire logic [pft_pkg::REQ_W-1:0]         in_tuser,  // req_type
  output logic                                   out_tvalid,
  input  wire logic                              out_tready,
  // status, slot_index, result_page, zero pad
  output logic      [pft_pkg::OUT_TDATA_W-1:0]   out_tdata,
  output logic                                   out_tuser  // candidate_valid
);
  import pft_pkg::*;

  pft_cmd_t cmd;

  pft_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .cmd        (cmd)
  );

  pft_dp #(
    .SLOTS     (SLOTS),
    .PAGE_BITS (PAGE_BITS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .in_req    (in_tuser),
    .in_page   (in_tdata),
    .out_tdata (out_tdata),
    .out_tuser (out_tuser)
  );

  // an accepted transfer goes straight into the compare step
  a_accept_search: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> cmd.search)
    else $error("accepted request did not start its search");

  // no new request taken while one is being resolved
  a_search_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.search |=> !in_tready)
    else $error("input ready during resolve");

  // a committed result is offered on the next cycle
  a_commit_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.commit |=> out_tvalid)
    else $error("committed result not presented");

  // a named candidate always comes with a miss
  a_cand_miss: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && out_tuser) |-> (out_tdata[1:0] == ST_MISS))
    else $error("candidate reported without miss status");

endmodule

`default_nettype wire

/* tb/sv/pft_checker.sv */
// Scoreboard for the page frame table unit: tracks the frame table and checks each result.
`default_nettype none

module pft_checker (
  input  wire logic                            clk,
  input  wire logic                            rst_n,
  input  wire logic                            in_tvalid,
  input  wire logic                            in_tready,
  input  wire logic [pft_pkg::IN_TDATA_W-1:0]  in_tdata,
  input  wire logic [pft_pkg::REQ_W-1:0]       in_tuser,
  input  wire logic                            out_tvalid,
  input  wire logic                            out_tready,
  input  wire logic [pft_pkg::OUT_TDATA_W-1:0] out_tdata,
  input  wire logic                            out_tuser,
  output int                                   mismatch_count,
  output int                                   pending_count,
  output int                                   checked_count,
  output int                                   candidate_count,
  output int                                   refused_count
);
  timeunit 1ns;
  timeprecision 1ps;
  import pft_pkg::*;

  localparam int FRAME_CNT = 16;
  localparam int SLOT_LSB  = STATUS_W;
  localparam int PAGE_LSB  = STATUS_W + SLOT_IDX_W;
  localparam int PAD_LSB   = PAGE_LSB + PAGE_W;

  typedef struct packed {
    logic [STATUS_W-1:0]   status;
    logic [SLOT_IDX_W-1:0] slot;
    logic [PAGE_W-1:0]     page;
    logic                  cand;
  } frame_result_t;

  // Shadow copy of the frame table
  logic [PAGE_W-1:0]     frame_page    [FRAME_CNT];
  logic                  frame_present [FRAME_CNT];
  logic [SLOT_IDX_W-1:0] hand;

  frame_result_t frame_results_q[$];
  int mismatches;
  int checked;
  int candidates;
  int refused;

  // First present frame holding pg, scanning from the hand; -1 if none.
  function automatic int find_frame(logic [PAGE_W-1:0] pg);
    int s;
    for (int i = 0; i < FRAME_CNT; i++) begin
      s = (int'(hand) + i) % FRAME_CNT;
      if (frame_present[s] && frame_page[s] == pg) return s;
    end
    return -1;
  endfunction

  // Applies one request to the shadow table and returns the result it should give.
  function automatic frame_result_t apply_request(logic [REQ_W-1:0] kind,
                                                  logic [PAGE_W-1:0] pg);
    frame_result_t r;
    int hit;
    int s;
    bit full;
    r = '0;
    r.status = ST_MISS;
    hit = -1;
    full = 1'b1;
    for (int i = 0; i < FRAME_CNT; i++)
      if (!frame_present[i]) full = 1'b0;
    case (kind)
      REQ_NEW: begin
        for (int i = 0; i < FRAME_CNT && hit < 0; i++) begin
          s = (int'(hand) + i) % FRAME_CNT;
          if (!frame_present[s]) hit = s;
        end
        if (hit >= 0) begin
          frame_page[hit] = pg;
          frame_present[hit] = 1'b1;
          hand = SLOT_IDX_W'((hit + 1) % FRAME_CNT);
          r.status = ST_OK;
          r.slot = SLOT_IDX_W'(hit);
        end else begin
          // full table: the frame under the hand is the victim
          r.page = frame_page[hand];
          r.cand = 1'b1;
        end
      end
      REQ_GET: begin
        hit = find_frame(pg);
        if (hit >= 0) begin
          r.status = ST_OK;
          r.slot = SLOT_IDX_W'(hit);
        end else if (full) begin
          r.page = frame_page[hand];
          r.cand = 1'b1;
        end
      end
      REQ_EVICT: begin
        hit = find_frame(pg);
        if (hit >= 0) begin
          frame_present[hit] = 1'b0;
          hand = SLOT_IDX_W'(hit);
          r.status = ST_OK;
          r.slot = SLOT_IDX_W'(hit);
        end else begin
          r.status = ST_ABSENT;
        end
      end
      default: begin
        for (int i = 0; i < FRAME_CNT && hit < 0; i++) begin
          s = (int'(hand) + i) % FRAME_CNT;
          if (frame_present[s]) hit = s;
        end
        if (hit >= 0) begin
          frame_present[hit] = 1'b0;
          r.status = ST_OK;
          r.slot = SLOT_IDX_W'(hit);
          r.page = frame_page[hit];
        end
      end
    endcase
    return r;
  endfunction

  task automatic check_field(string field, logic [63:0] exp_v, logic [63:0] act_v);
    if (act_v !== exp_v) begin
      $display("%0t: %s mismatch, expected 0x%0h, got 0x%0h", $time, field, exp_v, act_v);
      mismatches++;
    end
  endtask

  always @(posedge clk) begin
    frame_result_t want;
    if (!rst_n) begin
      for (int i = 0; i < FRAME_CNT; i++) frame_present[i] = 1'b0;
      hand = '0;
      frame_results_q.delete();
    end else begin
      // retire first: a result leaving now belongs to an older request
      if (out_tvalid && out_tready) begin
        if (frame_results_q.size() == 0) begin
          $display("%0t: unexpected result, expected none, got tdata 0x%0h tuser %0b",
                   $time, out_tdata, out_tuser);
          mismatches++;
        end else begin
          want = frame_results_q.pop_front();
          check_field("status", 64'(want.status), 64'(out_tdata[SLOT_LSB-1:0]));
          check_field("slot_index", 64'(want.slot), 64'(out_tdata[PAGE_LSB-1:SLOT_LSB]));
          check_field("result_page", 64'(want.page), 64'(out_tdata[PAD_LSB-1:PAGE_LSB]));
          check_field("candidate_valid", 64'(want.cand), 64'(out_tuser));
          check_field("tdata pad", 64'(0), 64'(out_tdata[OUT_TDATA_W-1:PAD_LSB]));
          checked++;
          if (want.cand) candidates++;
          if (want.status != ST_OK) refused++;
        end
      end
      if (in_tvalid && in_tready)
        frame_results_q.push_back(apply_request(in_tuser, in_tdata[PAGE_W-1:0]));
    end
    mismatch_count  <= mismatches;
    pending_count   <= frame_results_q.size();
    checked_count   <= checked;
    candidate_count <= candidates;
    refused_count   <= refused;
  end

endmodule

`default_nettype wire

/* tb/sv/tb_top.sv */
// Testbench top for the page frame table unit: clock, reset, stimulus and verdict.
`default_nettype none

module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import pft_pkg::*;

  localparam int POOL_SIZE      = 24;
  localparam int HOLD_CYCLES    = 300;   // long receiver hold-off
  localparam int WATCHDOG_LIMIT = 4000;  // cycles with no transfer on either side
  localparam int QUIET_CYCLES   = 20;    // settle time after the last result

  logic                   clk;
  logic                   rst_n      = 1'b0;
  logic                   in_tvalid  = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata   = '0;
  logic [REQ_W-1:0]       in_tuser   = REQ_NEW;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   out_tuser;

  int mismatch_count;
  int pending_count;
  int checked_count;
  int candidate_count;
  int refused_count;

  bit tx_idle_on    = 1'b1;
  bit rx_idle_on    = 1'b1;
  bit stall_request = 1'b0;
  int sent_count    = 0;

  logic [PAGE_W-1:0] page_pool [POOL_SIZE];

  page_frame_table_unit i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),   // page_number
    .in_tuser   (in_tuser),   // req_type
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),  // status, slot_index, result_page, pad
    .out_tuser  (out_tuser)   // candidate_valid
  );

  pft_checker i_checker (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_tvalid       (in_tvalid),
    .in_tready       (in_tready),
    .in_tdata        (in_tdata),
    .in_tuser        (in_tuser),
    .out_tvalid      (out_tvalid),
    .out_tready      (out_tready),
    .out_tdata       (out_tdata),
    .out_tuser       (out_tuser),
    .mismatch_count  (mismatch_count),
    .pending_count   (pending_count),
    .checked_count   (checked_count),
    .candidate_count (candidate_count),
    .refused_count   (refused_count)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // One request transfer; valid stays high afterwards unless the next call idles.
  task automatic send_request(input logic [REQ_W-1:0] kind, input logic [PAGE_W-1:0] pg);
    if (tx_idle_on) begin
      while ($urandom_range(99) < 14) begin
        in_tvalid <= 1'b0;
        @(posedge clk);
      end
    end
    in_tvalid <= 1'b1;
    in_tdata  <= pg;
    in_tuser  <= kind;
    do @(posedge clk); while (!in_tready);
    sent_count++;
  endtask

  // Stop offering until every outstanding result has come back.
  task automatic wait_drained();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (pending_count != 0);
  endtask

  // Mostly pages from a small pool so lookups and evictions hit, some fully random.
  function automatic logic [PAGE_W-1:0] pick_page();
    if ($urandom_range(99) < 75) return page_pool[$urandom_range(POOL_SIZE - 1)];
    return $urandom();
  endfunction

  function automatic logic [REQ_W-1:0] pick_kind(int w_new, int w_get, int w_evict);
    int r;
    r = $urandom_range(99);
    if (r < w_new) return REQ_NEW;
    if (r < w_new + w_get) return REQ_GET;
    if (r < w_new + w_get + w_evict) return REQ_EVICT;
    return REQ_POP;
  endfunction

  task automatic run_mix(int count, int w_new, int w_get, int w_evict);
    repeat (count) send_request(pick_kind(w_new, w_get, w_evict), pick_page());
  endtask

  // Result side: random back-pressure, plus one long hold-off on request.
  initial begin : receiver
    forever begin
      @(posedge clk);
      if (stall_request) begin
        stall_request = 1'b0;
        out_tready <= 1'b0;
        repeat (HOLD_CYCLES - 1) @(posedge clk);
      end else begin
        out_tready <= !(rx_idle_on && $urandom_range(99) < 14);
      end
    end
  end

  // Ends the run if neither channel moves for too long.
  initial begin : watchdog
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if (!rst_n || (in_tvalid && in_tready) || (out_tvalid && out_tready))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("%0t: no transfer for %0d cycles, %0d results outstanding",
             $time, WATCHDOG_LIMIT, pending_count);
    $display("** page_frame_table_unit: FAILED **");
    $finish;
  end

  initial begin : stimulus
    page_pool[0] = '0;
    page_pool[1] = '1;
    for (int i = 2; i < POOL_SIZE; i++) page_pool[i] = $urandom();

    repeat (6) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed: empty-table failures first
    send_request(REQ_POP, 32'hFFFF_FFFF);    // pop on empty table
    send_request(REQ_GET, 32'h0000_0000);    // miss with room, no candidate
    send_request(REQ_EVICT, 32'h0000_0000);  // evict of an absent page
    // Extreme pages and a duplicate
    send_request(REQ_NEW, 32'h0000_0000);
    send_request(REQ_NEW, 32'hFFFF_FFFF);
    send_request(REQ_NEW, 32'hA5A5_A5A5);
    send_request(REQ_NEW, 32'hFFFF_FFFF);
    send_request(REQ_GET, 32'hFFFF_FFFF);    // first match from the hand, wraps
    send_request(REQ_GET, 32'h5A5A_5A5A);    // miss with room
    send_request(REQ_EVICT, 32'hFFFF_FFFF);  // clears the first copy only
    send_request(REQ_GET, 32'hFFFF_FFFF);    // finds the second copy
    send_request(REQ_POP, 32'h0000_0000);
    // Fill to the brim, then hit the full-table cases
    repeat (14) send_request(REQ_NEW, $urandom());
    send_request(REQ_NEW, 32'h1234_5678);    // no free slot, candidate at the hand
    send_request(REQ_GET, 32'h8765_4321);    // miss on full table, candidate

    // Random: alternate fill-heavy and drain-heavy mixes so occupancy swings
    run_mix(300, 25, 25, 25);
    run_mix(250, 55, 25, 10);
    stall_request = 1'b1;                    // receiver holds off; the unit backs up
    run_mix(250, 15, 25, 30);
    wait_drained();

    // Stretch without any idling on either side
    tx_idle_on = 1'b0;
    rx_idle_on = 1'b0;
    run_mix(300, 25, 25, 25);
    tx_idle_on = 1'b1;
    rx_idle_on = 1'b1;
    run_mix(250, 60, 20, 10);
    run_mix(275, 15, 25, 30);

    wait_drained();
    repeat (QUIET_CYCLES) @(posedge clk);

    $display("Run covered %0d requests of all four kinds, %0d results checked,",
             sent_count, checked_count);
    $display("  %0d eviction candidates, %0d refused requests, long stall and drain pauses.",
             candidate_count, refused_count);
    if (mismatch_count == 0 && pending_count == 0)
      $display("** page_frame_table_unit: PASSED **");
    else
      $display("** page_frame_table_unit: FAILED **");
    $finish;
  end

endmodule

`default_nettype wire
